FILE: sv/scot_pkg.sv
`default_nettype none
package scot_pkg;
    localparam int unsigned CoordW = 32;
    localparam int unsigned RadW = 31;
    localparam int unsigned DefFracBits = 16;
    localparam int unsigned DiffW = CoordW + 1;
    localparam int unsigned MagW = CoordW;
    localparam int unsigned SqW = 2 * MagW + 2;
    localparam int unsigned DotW = 2 * MagW + 3;
    localparam int unsigned RsumW = RadW + 1;
    localparam int unsigned R2W = 2 * RsumW;

    typedef struct packed {
        logic signed [CoordW-1:0] sphere_x;
        logic signed [CoordW-1:0] sphere_y;
        logic signed [CoordW-1:0] sphere_z;
        logic [RadW-1:0] sphere_radius;
        logic signed [CoordW-1:0] axis_start_x;
        logic signed [CoordW-1:0] axis_start_y;
        logic signed [CoordW-1:0] axis_start_z;
        logic signed [CoordW-1:0] axis_end_x;
        logic signed [CoordW-1:0] axis_end_y;
        logic signed [CoordW-1:0] axis_end_z;
        logic [RadW-1:0] capsule_radius;
    } t_query;

    typedef struct packed {
        logic hit;
        logic degenerate_axis;
    } t_result;
endpackage
`default_nettype wire

FILE: sv/scot_if.sv
`default_nettype none
interface scot_query_if;
    logic valid;
    logic ready;
    scot_pkg::t_query data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface scot_result_if;
    logic valid;
    logic ready;
    scot_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/sphere_capsule_overlap_test_top.sv
// sphere against capsule overlap test, fully pipelined
// i_query (sink): one word per query, sphere centre and radius, capsule axis
//   end points and radius, all Q16.16
// o_result (source): one word per query, in order: hit and degenerate_axis
// a word is moved when valid and ready are both high at a rising edge
// throughput: one query per cycle unless the receiver stalls; the long products are split
//   into 33x33 partial products spread over the stages, which sets the depth
// reset (i_rst_n low, synchronous) empties every stage; payload is not cleared
// when the receiver holds ready low the whole pipe freezes in place and
//   i_query.ready follows it, so nothing is dropped or repeated; with an
//   empty stage in front the pipe still advances (bubbles are squeezed out)
// hit compares squared distances exactly, so FRAC_BITS does not affect results
`default_nettype none
module sphere_capsule_overlap_test_top #(
    parameter int unsigned FRAC_BITS = scot_pkg::DefFracBits
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    scot_query_if.sink i_query,
    scot_result_if.source o_result
);
    localparam int unsigned NSt = 8;
    localparam int unsigned DW = scot_pkg::DiffW;
    localparam int unsigned MW = scot_pkg::MagW;
    localparam int unsigned SW = scot_pkg::SqW;
    localparam int unsigned PW = scot_pkg::DotW;
    localparam int unsigned RW = scot_pkg::R2W;
    localparam int unsigned HW = SW / 2;
    localparam int unsigned BigW = 2 * SW + 1;

    logic [NSt-1:0] r_vld;
    logic [NSt-1:0] adv;

    // a stage moves when the one after it moves or when it is empty
    always_comb begin
        adv[NSt-1] = o_result.ready || !r_vld[NSt-1];
        for (int k = NSt - 2; k >= 0; k--) begin
            adv[k] = adv[k+1] || !r_vld[k];
        end
    end
    assign i_query.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_query.valid;
            for (int k = 1; k < NSt; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    function automatic logic [MW-1:0] f_mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(-v) : DW'(v);
        return m[MW-1:0];
    endfunction

    // stage 0: differences, magnitudes and signs
    logic [MW-1:0] r0_dm [3], r0_wm [3], r0_em [3];
    logic [2:0] r0_ds, r0_ws;
    logic [scot_pkg::RsumW-1:0] r0_r;
    logic r0_dz;
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            logic signed [DW-1:0] s [3], a [3], b [3], d [3], w [3], e [3];
            s[0] = DW'(i_query.data.sphere_x);
            s[1] = DW'(i_query.data.sphere_y);
            s[2] = DW'(i_query.data.sphere_z);
            a[0] = DW'(i_query.data.axis_start_x);
            a[1] = DW'(i_query.data.axis_start_y);
            a[2] = DW'(i_query.data.axis_start_z);
            b[0] = DW'(i_query.data.axis_end_x);
            b[1] = DW'(i_query.data.axis_end_y);
            b[2] = DW'(i_query.data.axis_end_z);
            for (int i = 0; i < 3; i++) begin
                d[i] = b[i] - a[i];
                w[i] = s[i] - a[i];
                e[i] = s[i] - b[i];
                r0_dm[i] <= f_mag(d[i]);
                r0_wm[i] <= f_mag(w[i]);
                r0_em[i] <= f_mag(e[i]);
                r0_ds[i] <= d[i][DW-1];
                r0_ws[i] <= w[i][DW-1];
            end
            r0_dz <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
            r0_r <= scot_pkg::RsumW'(i_query.data.sphere_radius)
                  + scot_pkg::RsumW'(i_query.data.capsule_radius);
        end
    end

    // stage 1: 32x32 products
    logic [2*MW-1:0] r1_dd [3], r1_ww [3], r1_ee [3], r1_dw [3];
    logic [2:0] r1_neg;
    logic [RW-1:0] r1_r2;
    logic r1_dz;
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_dd[i] <= r0_dm[i] * r0_dm[i];
                r1_ww[i] <= r0_wm[i] * r0_wm[i];
                r1_ee[i] <= r0_em[i] * r0_em[i];
                r1_dw[i] <= r0_dm[i] * r0_wm[i];
                r1_neg[i] <= r0_ds[i] ^ r0_ws[i];
            end
            r1_r2 <= r0_r * r0_r;
            r1_dz <= r0_dz;
        end
    end

    // stage 2: sums and dot product
    logic [SW-1:0] r2_len2, r2_w2, r2_e2;
    logic signed [PW-1:0] r2_dot;
    logic [RW-1:0] r2_r2;
    logic r2_dz;
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            logic signed [PW-1:0] acc;
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                if (r1_neg[i]) acc = acc - PW'(r1_dw[i]);
                else acc = acc + PW'(r1_dw[i]);
            end
            r2_dot <= acc;
            r2_len2 <= SW'(r1_dd[0]) + SW'(r1_dd[1]) + SW'(r1_dd[2]);
            r2_w2 <= SW'(r1_ww[0]) + SW'(r1_ww[1]) + SW'(r1_ww[2]);
            r2_e2 <= SW'(r1_ee[0]) + SW'(r1_ee[1]) + SW'(r1_ee[2]);
            r2_r2 <= r1_r2;
            r2_dz <= r1_dz;
        end
    end

    // stage 3: classify region, pick end-point tests
    logic [SW-1:0] r3_len2, r3_w2, r3_dm;
    logic [RW-1:0] r3_r2;
    logic r3_mid, r3_endhit, r3_dz;
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            logic start_side, past_end;
            start_side = r2_dz || (r2_dot <= 0);
            past_end = !start_side && (SW'(r2_dot) > r2_len2);
            r3_mid <= !start_side && !past_end;
            r3_endhit <= start_side ? (r2_w2 < SW'(r2_r2)) : (r2_e2 < SW'(r2_r2));
            r3_dm <= SW'(r2_dot);
            r3_len2 <= r2_len2;
            r3_w2 <= r2_w2;
            r3_r2 <= r2_r2;
            r3_dz <= r2_dz;
        end
    end

    // stages 4-5: wide products as 33x33 partial products, summed next stage
    logic [SW-1:0] r4_p [3][4];
    logic r4_mid, r4_endhit, r4_dz;
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            logic [SW-1:0] x [3], y [3];
            x[0] = r3_w2;  y[0] = r3_len2;
            x[1] = SW'(r3_r2); y[1] = r3_len2;
            x[2] = r3_dm;  y[2] = r3_dm;
            for (int m = 0; m < 3; m++) begin
                r4_p[m][0] <= x[m][HW-1:0] * y[m][HW-1:0];
                r4_p[m][1] <= x[m][HW-1:0] * y[m][SW-1:HW];
                r4_p[m][2] <= x[m][SW-1:HW] * y[m][HW-1:0];
                r4_p[m][3] <= x[m][SW-1:HW] * y[m][SW-1:HW];
            end
            r4_mid <= r3_mid;
            r4_endhit <= r3_endhit;
            r4_dz <= r3_dz;
        end
    end

    logic [BigW-1:0] r5_prod [3];
    logic r5_mid, r5_endhit, r5_dz;
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int m = 0; m < 3; m++) begin
                r5_prod[m] <= BigW'(r4_p[m][0])
                            + (BigW'(r4_p[m][1]) << HW)
                            + (BigW'(r4_p[m][2]) << HW)
                            + (BigW'(r4_p[m][3]) << (2 * HW));
            end
            r5_mid <= r4_mid;
            r5_endhit <= r4_endhit;
            r5_dz <= r4_dz;
        end
    end

    // stage 6: right-hand sum
    logic [BigW-1:0] r6_lhs, r6_rhs;
    logic r6_mid, r6_endhit, r6_dz;
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_lhs <= r5_prod[0];
            r6_rhs <= r5_prod[1] + r5_prod[2];
            r6_mid <= r5_mid;
            r6_endhit <= r5_endhit;
            r6_dz <= r5_dz;
        end
    end

    // stage 7: final compare, output word
    scot_pkg::t_result r7_res;
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_res.hit <= r6_mid ? (r6_lhs < r6_rhs) : r6_endhit;
            r7_res.degenerate_axis <= r6_dz;
        end
    end

    assign o_result.valid = r_vld[NSt-1];
    assign o_result.data = r7_res;

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=> o_result.valid && $stable(o_result.data))
        else $error("result changed under stall");
    // degenerate axis never takes the interior path
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> !(r3_dz && r3_mid))
        else $error("degenerate axis classified interior");
    // an accepted query reaches the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_query.valid && i_query.ready |=> r_vld[0])
        else $error("accepted query lost");
    // stalled pipe with full output keeps the stage before it
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSt-1] && r_vld[NSt-2] && !o_result.ready |=> r_vld[NSt-2])
        else $error("stage lost under stall");
endmodule
`default_nettype wire

FILE: sim/scot_overlap_scoreboard.sv
package scot_overlap_sb_pkg;

    class overlap_scoreboard;
        scot_pkg::t_result expected_q[$];
        int unsigned n_fail;

        function new();
            n_fail = 0;
        endfunction

        static function logic [255:0] mag_of(logic signed [33:0] v);
            logic [255:0] m;
            m = (v < 0) ? 256'(-v) : 256'(v);
            return m;
        endfunction

        static function logic [255:0] sq_len(logic signed [33:0] x, logic signed [33:0] y,
                                             logic signed [33:0] z);
            logic [255:0] s;
            s = mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y) + mag_of(z) * mag_of(z);
            return s;
        endfunction

        // exact closest-point test on the capsule axis
        static function scot_pkg::t_result predict_overlap(scot_pkg::t_query q);
            scot_pkg::t_result res;
            logic signed [33:0] sx, sy, sz, ax, ay, az, bx, by, bz;
            logic signed [33:0] dx, dy, dz, wx, wy, wz;
            logic signed [255:0] dot;
            logic [255:0] len2, w2, r2, rsum, dmag;
            sx = 34'(q.sphere_x); sy = 34'(q.sphere_y); sz = 34'(q.sphere_z);
            ax = 34'(q.axis_start_x); ay = 34'(q.axis_start_y); az = 34'(q.axis_start_z);
            bx = 34'(q.axis_end_x); by = 34'(q.axis_end_y); bz = 34'(q.axis_end_z);
            dx = bx - ax; dy = by - ay; dz = bz - az;
            wx = sx - ax; wy = sy - ay; wz = sz - az;
            dot = 256'(dx) * 256'(wx) + 256'(dy) * 256'(wy) + 256'(dz) * 256'(wz);
            len2 = sq_len(dx, dy, dz);
            w2 = sq_len(wx, wy, wz);
            rsum = 256'(q.sphere_radius) + 256'(q.capsule_radius);
            r2 = rsum * rsum;
            res.degenerate_axis = (dx == 0 && dy == 0 && dz == 0);
            if (res.degenerate_axis || dot <= 0) begin
                res.hit = w2 < r2;
            end else begin
                dmag = dot;
                if (dmag > len2) begin
                    res.hit = sq_len(sx - bx, sy - by, sz - bz) < r2;
                end else begin
                    res.hit = w2 * len2 < r2 * len2 + dmag * dmag;
                end
            end
            return res;
        endfunction

        function void note_query(scot_pkg::t_query q);
            expected_q.push_back(predict_overlap(q));
        endfunction

        function void check_result(scot_pkg::t_result got);
            scot_pkg::t_result exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0b degenerate_axis=%0b",
                         $time, got.hit, got.degenerate_axis);
                n_fail++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.hit !== exp.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, exp.hit, got.hit);
                n_fail++;
            end
            if (got.degenerate_axis !== exp.degenerate_axis) begin
                $display("%0t: degenerate_axis expected %0b actual %0b", $time,
                         exp.degenerate_axis, got.degenerate_axis);
                n_fail++;
            end
        endfunction
    endclass
endpackage

FILE: sim/tb_sphere_capsule_overlap_test_top.sv
`default_nettype none
module tb_sphere_capsule_overlap_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WatchdogLimit = 5000;
    localparam int unsigned RandQueries = 1030;

    logic i_clk;
    logic i_rst_n;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int unsigned idle_cycles;
    bit timed_out;

    scot_query_if i_query ();
    scot_result_if o_result ();
    scot_overlap_sb_pkg::overlap_scoreboard sb;

    sphere_capsule_overlap_test_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_query(i_query.sink),
        .o_result(o_result.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin
        o_result.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                o_result.ready <= 1'b0;
            end else begin
                o_result.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result.valid && o_result.ready) begin
            sb.check_result(o_result.data);
        end
        if (i_rst_n && i_query.valid && i_query.ready) begin
            sb.note_query(i_query.data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_query.valid && i_query.ready) || (o_result.valid && o_result.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $signed($urandom_range(2000)) - 1000;
            2: v = 32'h7fffffff - $urandom_range(3);
            3: v = 32'sh80000000 + $urandom_range(3);
            default: v = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] rand_radius();
        logic [30:0] r;
        case ($urandom_range(3))
            0: r = 31'($urandom);
            1: r = '0;
            2: r = 31'h7fffffff;
            default: r = 31'($urandom_range(32'h00300000));
        endcase
        return r;
    endfunction

    // mostly queries placed near the capsule so that hits and misses are both common
    function automatic scot_pkg::t_query rand_query();
        scot_pkg::t_query q;
        logic signed [31:0] base;
        q.axis_start_x = rand_coord(); q.axis_start_y = rand_coord();
        q.axis_start_z = rand_coord();
        if ($urandom_range(9) == 0) begin
            q.axis_end_x = q.axis_start_x; q.axis_end_y = q.axis_start_y;
            q.axis_end_z = q.axis_start_z;
        end else begin
            q.axis_end_x = rand_coord(); q.axis_end_y = rand_coord(); q.axis_end_z = rand_coord();
        end
        if ($urandom_range(2) != 0) begin
            base = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
            q.axis_start_x = base;
            q.axis_end_x = base + $signed($urandom_range(32'h00040000)) - 32'sh00020000;
            q.axis_start_y = $signed($urandom_range(32'h0000ffff)) - 32'sh8000;
            q.axis_end_y = $signed($urandom_range(32'h0000ffff)) - 32'sh8000;
            q.axis_start_z = $signed($urandom_range(32'h0000ffff)) - 32'sh8000;
            q.axis_end_z = $signed($urandom_range(32'h0000ffff)) - 32'sh8000;
            q.sphere_x = base + $signed($urandom_range(32'h00060000)) - 32'sh00030000;
            q.sphere_y = $signed($urandom_range(32'h00040000)) - 32'sh00020000;
            q.sphere_z = $signed($urandom_range(32'h00040000)) - 32'sh00020000;
            q.sphere_radius = 31'($urandom_range(32'h00018000));
            q.capsule_radius = 31'($urandom_range(32'h00018000));
        end else begin
            q.sphere_x = rand_coord(); q.sphere_y = rand_coord(); q.sphere_z = rand_coord();
            q.sphere_radius = rand_radius();
            q.capsule_radius = rand_radius();
        end
        return q;
    endfunction

    function automatic scot_pkg::t_query make_query(int sx, int sy, int sz, int rs, int ax,
                                                    int ay, int az, int bx, int by, int bz,
                                                    int rc);
        scot_pkg::t_query q;
        q.sphere_x = sx; q.sphere_y = sy; q.sphere_z = sz; q.sphere_radius = rs[30:0];
        q.axis_start_x = ax; q.axis_start_y = ay; q.axis_start_z = az;
        q.axis_end_x = bx; q.axis_end_y = by; q.axis_end_z = bz;
        q.capsule_radius = rc[30:0];
        return q;
    endfunction

    task automatic send_query(scot_pkg::t_query q);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_query.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_query.valid <= 1'b1;
        i_query.data <= q;
        @(posedge i_clk);
        while (!i_query.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_query.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (n) send_query(rand_query());
    endtask

    initial begin
        scot_pkg::t_query dq[$];
        int k;
        sb = new();
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        i_rst_n = 1'b0;
        i_query.valid = 1'b0;
        i_query.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate axis, hit and miss
        dq.push_back(make_query(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 65536));
        dq.push_back(make_query(200000, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 65536));
        // projection exactly at the start, miss and touching
        dq.push_back(make_query(0, 65536, 0, 32768, 0, 0, 0, 262144, 0, 0, 32767));
        dq.push_back(make_query(0, 65536, 0, 32768, 0, 0, 0, 262144, 0, 0, 32768));
        // projection exactly at the end
        dq.push_back(make_query(262144, 65536, 0, 32768, 0, 0, 0, 262144, 0, 0, 32769));
        // beyond the end and before the start
        dq.push_back(make_query(400000, 0, 0, 65536, 0, 0, 0, 262144, 0, 0, 65536));
        dq.push_back(make_query(-100000, 0, 0, 65536, 0, 0, 0, 262144, 0, 0, 65536));
        // interior touching and just inside
        dq.push_back(make_query(100000, 0, 3, 1, 0, 0, 0, 262144, 0, 0, 2));
        dq.push_back(make_query(100000, 0, 3, 1, 0, 0, 0, 262144, 0, 0, 3));
        // zero radii
        dq.push_back(make_query(5, 5, 5, 0, 5, 5, 5, 9, 9, 9, 0));
        // extreme coordinates and radii
        dq.push_back(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        dq.push_back(make_query(32'h80000000, 32'h7fffffff, 32'h80000000, 0,
                                32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                32'h80000000, 32'h80000000, 32'h80000000, 0));
        dq.push_back(make_query(-1, -1, -1, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff,
                                32'h7fffffff, -1, 32'h80000000, 32'h7fffffff));
        dq.push_back(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                32'h80000000, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
        dq.push_back(make_query(0, 0, 0, 32'h40000000, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
        for (k = 0; k < dq.size(); k++) send_query(dq[k]);

        run_phase(200, 0, 0);
        run_phase(200, 61, 0);
        run_phase(200, 0, 61);
        run_phase(200, 17, 17);

        // long receiver hold-off while the sender keeps offering words
        hold_off = 1'b1;
        fork
            run_phase(60, 0, 0);
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        // sender pauses until the pipe is empty
        drain();
        run_phase(RandQueries - 860, 17, 17);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
